[hdl/tcfa_pkg.sv]
// Shared types and codes for the typed constant-folding ALU.
`default_nettype none
package tcfa_pkg;

   typedef enum logic [4:0] {
      OP_ADD   = 5'd0,
      OP_SUB   = 5'd1,
      OP_SLASH = 5'd2,
      OP_MUL   = 5'd3,
      OP_DIV   = 5'd4,
      OP_MOD   = 5'd5,
      OP_AND   = 5'd6,
      OP_OR    = 5'd7,
      OP_EQ    = 5'd8,
      OP_NEQ   = 5'd9,
      OP_LT    = 5'd10,
      OP_LEQ   = 5'd11,
      OP_GT    = 5'd12,
      OP_GEQ   = 5'd13,
      OP_IN    = 5'd14,
      OP_NEG   = 5'd15,
      OP_NOT   = 5'd16
   } opcode_type;

   localparam logic [1:0] KIND_INT  = 2'd0;
   localparam logic [1:0] KIND_BOOL = 2'd1;
   localparam logic [1:0] KIND_SET  = 2'd2;

   localparam logic [2:0] ERR_OK       = 3'd0;
   localparam logic [2:0] ERR_KIND_DIF = 3'd1;
   localparam logic [2:0] ERR_KIND_BAD = 3'd2;
   localparam logic [2:0] ERR_IN_OPND  = 3'd3;
   localparam logic [2:0] ERR_OPCODE   = 3'd4;
   localparam logic [2:0] ERR_DIV_ZERO = 3'd5;

   // Back-end unit that finishes an item.
   typedef enum logic [1:0] {
      UNIT_LOGIC = 2'd0,
      UNIT_MUL   = 2'd1,
      UNIT_DIV   = 2'd2
   } unit_type;

   localparam int DivSteps = 64;

   // Classified item passed from front to back.
   typedef struct packed {
      unit_type    unit;
      logic [4:0]  opcode;
      logic        quot_trunc;  // slash: no floor correction
      logic        want_rem;
      logic [63:0] lhs;
      logic [63:0] rhs;
      logic [63:0] value;       // finished value for logic unit
      logic [1:0]  kind;
      logic [2:0]  err;
   } cmd_type;

   typedef struct packed {
      logic [63:0] value;
      logic [1:0]  kind;
      logic [2:0]  err;
   } rsp_type;

endpackage
`default_nettype wire

[hdl/tcfa_front.sv]
// Front end: check kinds and compute the operations that need no back-end unit.
`default_nettype none
module tcfa_front #(
   parameter int SET_WIDTH = 32
) (
   input  wire logic [4:0]     opcode,
   input  wire logic [1:0]     lhs_kind,
   input  wire logic [1:0]     rhs_kind,
   input  wire logic [63:0]    lhs_value,
   input  wire logic [63:0]    rhs_value,
   output tcfa_pkg::cmd_type   cmd
);

   localparam logic [63:0] SetMask = (SET_WIDTH >= 64) ? '1 :
      ((64'd1 << SET_WIDTH) - 64'd1);

   logic [63:0] sa, sb;
   logic        lt_ab, lt_ba;

   assign sa    = lhs_value & SetMask;
   assign sb    = rhs_value & SetMask;
   assign lt_ab = $signed(lhs_value) < $signed(rhs_value);
   assign lt_ba = $signed(rhs_value) < $signed(lhs_value);

   always_comb begin
      cmd            = '0;
      cmd.unit       = tcfa_pkg::UNIT_LOGIC;
      cmd.opcode     = opcode;
      cmd.lhs        = lhs_value;
      cmd.rhs        = rhs_value;
      cmd.quot_trunc = (opcode == tcfa_pkg::OP_SLASH);
      cmd.want_rem   = (opcode == tcfa_pkg::OP_MOD);
      cmd.kind       = tcfa_pkg::KIND_INT;
      cmd.err        = tcfa_pkg::ERR_OK;
      if (opcode > tcfa_pkg::OP_NOT) begin
         cmd.err = tcfa_pkg::ERR_OPCODE;
      end else if (opcode == tcfa_pkg::OP_IN) begin
         if (lhs_kind != tcfa_pkg::KIND_INT || rhs_kind != tcfa_pkg::KIND_SET ||
             lhs_value[63] || lhs_value >= 64'(SET_WIDTH)) begin
            cmd.err = tcfa_pkg::ERR_IN_OPND;
         end else begin
            cmd.value = {63'd0, rhs_value[lhs_value[5:0]]};
            cmd.kind  = tcfa_pkg::KIND_BOOL;
         end
      end else if (opcode == tcfa_pkg::OP_NEG) begin
         if (lhs_kind == tcfa_pkg::KIND_INT) cmd.value = 64'd0 - lhs_value;
         else cmd.err = tcfa_pkg::ERR_KIND_BAD;
      end else if (opcode == tcfa_pkg::OP_NOT) begin
         if (lhs_kind == tcfa_pkg::KIND_BOOL) begin
            cmd.value = {63'd0, ~lhs_value[0]};
            cmd.kind  = tcfa_pkg::KIND_BOOL;
         end else cmd.err = tcfa_pkg::ERR_KIND_BAD;
      end else if (lhs_kind != rhs_kind) begin
         cmd.err = tcfa_pkg::ERR_KIND_DIF;
      end else if (lhs_kind == tcfa_pkg::KIND_INT) begin
         case (opcode)
            tcfa_pkg::OP_ADD: cmd.value = lhs_value + rhs_value;
            tcfa_pkg::OP_SUB: cmd.value = lhs_value - rhs_value;
            tcfa_pkg::OP_MUL: cmd.unit = tcfa_pkg::UNIT_MUL;
            tcfa_pkg::OP_SLASH, tcfa_pkg::OP_DIV, tcfa_pkg::OP_MOD: begin
               if (rhs_value == 64'd0) cmd.err = tcfa_pkg::ERR_DIV_ZERO;
               else cmd.unit = tcfa_pkg::UNIT_DIV;
            end
            tcfa_pkg::OP_EQ: begin
               cmd.value = {63'd0, lhs_value == rhs_value};
               cmd.kind  = tcfa_pkg::KIND_BOOL;
            end
            tcfa_pkg::OP_NEQ: begin
               cmd.value = {63'd0, lhs_value != rhs_value};
               cmd.kind  = tcfa_pkg::KIND_BOOL;
            end
            tcfa_pkg::OP_LT: begin
               cmd.value = {63'd0, lt_ab};
               cmd.kind  = tcfa_pkg::KIND_BOOL;
            end
            tcfa_pkg::OP_LEQ: begin
               cmd.value = {63'd0, ~lt_ba};
               cmd.kind  = tcfa_pkg::KIND_BOOL;
            end
            tcfa_pkg::OP_GT: begin
               cmd.value = {63'd0, lt_ba};
               cmd.kind  = tcfa_pkg::KIND_BOOL;
            end
            tcfa_pkg::OP_GEQ: begin
               cmd.value = {63'd0, ~lt_ab};
               cmd.kind  = tcfa_pkg::KIND_BOOL;
            end
            default: cmd.err = tcfa_pkg::ERR_KIND_BAD;
         endcase
      end else if (lhs_kind == tcfa_pkg::KIND_BOOL) begin
         cmd.kind = tcfa_pkg::KIND_BOOL;
         case (opcode)
            tcfa_pkg::OP_AND: cmd.value = {63'd0, lhs_value[0] & rhs_value[0]};
            tcfa_pkg::OP_OR:  cmd.value = {63'd0, lhs_value[0] | rhs_value[0]};
            tcfa_pkg::OP_EQ:  cmd.value = {63'd0, ~(lhs_value[0] ^ rhs_value[0])};
            tcfa_pkg::OP_NEQ: cmd.value = {63'd0, lhs_value[0] ^ rhs_value[0]};
            default:          cmd.err = tcfa_pkg::ERR_KIND_BAD;
         endcase
      end else if (lhs_kind == tcfa_pkg::KIND_SET) begin
         cmd.kind = tcfa_pkg::KIND_SET;
         case (opcode)
            tcfa_pkg::OP_ADD:   cmd.value = sa | sb;
            tcfa_pkg::OP_SUB:   cmd.value = sa & ~sb;
            tcfa_pkg::OP_SLASH: cmd.value = sa ^ sb;
            tcfa_pkg::OP_MUL:   cmd.value = sa & sb;
            tcfa_pkg::OP_EQ: begin
               cmd.value = {63'd0, sa == sb};
               cmd.kind  = tcfa_pkg::KIND_BOOL;
            end
            tcfa_pkg::OP_NEQ: begin
               cmd.value = {63'd0, sa != sb};
               cmd.kind  = tcfa_pkg::KIND_BOOL;
            end
            default: cmd.err = tcfa_pkg::ERR_KIND_BAD;
         endcase
      end else begin
         cmd.err = tcfa_pkg::ERR_KIND_BAD;
      end
      if (cmd.err != tcfa_pkg::ERR_OK) begin
         cmd.value = '0;
         cmd.kind  = tcfa_pkg::KIND_INT;
         cmd.unit  = tcfa_pkg::UNIT_LOGIC;
      end
   end

endmodule
`default_nettype wire

[hdl/tcfa_queue.sv]
// Small FIFO between the front end and the back end.
`default_nettype none
module tcfa_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  tcfa_pkg::cmd_type      push_data,
   output logic                   full,
   input  wire logic              pop,
   output tcfa_pkg::cmd_type      pop_data,
   output logic                   empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   tcfa_pkg::cmd_type mem [DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic          do_push, do_pop;

   assign full     = (cnt_ff == (AW+1)'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) wr_in = (wr_ff == AW'(DEPTH-1)) ? '0 : wr_ff + 1'b1;
      if (do_pop)  rd_in = (rd_ff == AW'(DEPTH-1)) ? '0 : rd_ff + 1'b1;
      if (do_push && !do_pop) cnt_in = cnt_ff + 1'b1;
      else if (do_pop && !do_push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem[wr_ff] <= push_data;
   end

endmodule
`default_nettype wire

[hdl/tcfa_back.sv]
// Back end: pipelined multiply and radix-2 pipelined divide, floored or truncating.
`default_nettype none
module tcfa_back (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   input  tcfa_pkg::cmd_type  in_cmd,
   output logic               in_ready,
   output logic               out_valid,
   output tcfa_pkg::rsp_type  out_rsp,
   input  wire logic          out_ready
);

   localparam int NS = tcfa_pkg::DivSteps;
   // stages: 0 entry/abs, 1..NS divide steps, NS+1 sign fix, NS+2 floor fix
   localparam int LAST = NS + 2;

   typedef struct packed {
      tcfa_pkg::unit_type unit;
      logic        trunc;
      logic        want_rem;
      logic        na;
      logic        nb;
      logic [63:0] b;
      logic [63:0] ub;
      logic [63:0] rem;
      logic [63:0] quo;   // dividend bits shifted out into quotient
      logic [63:0] value;
      logic [1:0]  kind;
      logic [2:0]  err;
   } stg_type;

   stg_type     stg_ff [LAST+1];
   stg_type     stg_in [LAST+1];
   logic        vld_ff [LAST+1];
   logic        adv;
   logic [31:0] pp_ff [4];
   logic [63:0] mul_full;

   // whole pipe stalls together when the result stage is held
   assign adv       = !(vld_ff[LAST] && !out_ready);
   assign in_ready  = adv;
   assign out_valid = vld_ff[LAST];
   assign out_rsp   = '{value: stg_ff[LAST].value, kind: stg_ff[LAST].kind,
                        err: stg_ff[LAST].err};

   // 32x32 partial products registered in stage 0, summed in stage 1
   always_ff @(posedge clock) begin
      if (adv) begin
         pp_ff[0] <= 32'(in_cmd.lhs[31:0] * in_cmd.rhs[31:0]);
         pp_ff[1] <= 32'((64'(in_cmd.lhs[31:0]) * 64'(in_cmd.rhs[31:0])) >> 32);
         pp_ff[2] <= 32'(in_cmd.lhs[63:32] * in_cmd.rhs[31:0]);
         pp_ff[3] <= 32'(in_cmd.lhs[31:0] * in_cmd.rhs[63:32]);
      end
   end
   assign mul_full = {pp_ff[1] + pp_ff[2] + pp_ff[3], pp_ff[0]};

   always_comb begin
      logic [64:0] trial;
      logic [63:0] rsh;
      for (int i = 0; i <= LAST; i++) stg_in[i] = '0;
      // entry
      stg_in[0].unit     = in_cmd.unit;
      stg_in[0].trunc    = in_cmd.quot_trunc;
      stg_in[0].want_rem = in_cmd.want_rem;
      stg_in[0].na       = in_cmd.lhs[63];
      stg_in[0].nb       = in_cmd.rhs[63];
      stg_in[0].b        = in_cmd.rhs;
      stg_in[0].ub       = in_cmd.rhs[63] ? 64'd0 - in_cmd.rhs : in_cmd.rhs;
      stg_in[0].quo      = in_cmd.lhs[63] ? 64'd0 - in_cmd.lhs : in_cmd.lhs;
      stg_in[0].rem      = '0;
      stg_in[0].value    = in_cmd.value;
      stg_in[0].kind     = in_cmd.kind;
      stg_in[0].err      = in_cmd.err;
      // one restoring step per stage
      for (int i = 1; i <= NS; i++) begin
         stg_in[i] = stg_ff[i-1];
         trial = {stg_ff[i-1].rem, stg_ff[i-1].quo[63]} - {1'b0, stg_ff[i-1].ub};
         rsh   = {stg_ff[i-1].rem[62:0], stg_ff[i-1].quo[63]};
         stg_in[i].quo = {stg_ff[i-1].quo[62:0], !trial[64]};
         stg_in[i].rem = trial[64] ? rsh : trial[63:0];
         if (i == 1 && stg_ff[0].unit == tcfa_pkg::UNIT_MUL)
            stg_in[i].value = mul_full;
      end
      // apply signs of truncating division
      stg_in[NS+1] = stg_ff[NS];
      stg_in[NS+1].quo = (stg_ff[NS].na != stg_ff[NS].nb) ?
         64'd0 - stg_ff[NS].quo : stg_ff[NS].quo;
      stg_in[NS+1].rem = stg_ff[NS].na ? 64'd0 - stg_ff[NS].rem : stg_ff[NS].rem;
      // floor correction and select
      stg_in[LAST] = stg_ff[NS+1];
      if (stg_ff[NS+1].unit == tcfa_pkg::UNIT_DIV) begin
         if (!stg_ff[NS+1].trunc && stg_ff[NS+1].rem != '0 &&
             (stg_ff[NS+1].rem[63] != stg_ff[NS+1].b[63])) begin
            stg_in[LAST].value = stg_ff[NS+1].want_rem ?
               stg_ff[NS+1].rem + stg_ff[NS+1].b : stg_ff[NS+1].quo - 64'd1;
         end else begin
            stg_in[LAST].value = stg_ff[NS+1].want_rem ?
               stg_ff[NS+1].rem : stg_ff[NS+1].quo;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= LAST; i++) vld_ff[i] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= in_valid;
         for (int i = 1; i <= LAST; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i <= LAST; i++) stg_ff[i] <= stg_in[i];
      end
   end

endmodule
`default_nettype wire

[hdl/typed_const_fold_alu_top.sv]
// Top level of the typed constant-folding ALU.
//  channel | ports                                   | direction
//  request | req_push, req_full, req_* fields        | in
//  result  | rsp_pop, rsp_empty, rsp_* fields        | out
// One transaction per cycle sustained while no queue fills. A request passes
// through the command queue, the 67 back-end stages set by the 64-step
// divider, and the result queue.
// Reset clears all queue pointers and stage valid bits.
// A held result stalls the back-end pipe once the result queue fills; the
// queues absorb the slack.
`default_nettype none
module typed_const_fold_alu_top #(
   parameter int SET_WIDTH = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_push,
   output logic              req_full,
   input  wire logic [4:0]   req_opcode,
   input  wire logic [1:0]   req_lhs_kind,
   input  wire logic [1:0]   req_rhs_kind,
   input  wire logic [63:0]  req_lhs_value,
   input  wire logic [63:0]  req_rhs_value,
   output logic              rsp_empty,
   input  wire logic         rsp_pop,
   output logic [63:0]       rsp_result_value,
   output logic [1:0]        rsp_result_kind,
   output logic [2:0]        rsp_error_code
);

   tcfa_pkg::cmd_type cmd, q_cmd;
   tcfa_pkg::rsp_type b_rsp, o_rsp;
   logic q_empty, b_ready, b_valid, o_full;

   tcfa_front #(.SET_WIDTH(SET_WIDTH)) u_front (
      .opcode(req_opcode), .lhs_kind(req_lhs_kind), .rhs_kind(req_rhs_kind),
      .lhs_value(req_lhs_value), .rhs_value(req_rhs_value), .cmd(cmd));

   tcfa_queue #(.DEPTH(4)) u_cmdq (
      .clock(clock), .reset(reset), .push(req_push), .push_data(cmd),
      .full(req_full), .pop(b_ready), .pop_data(q_cmd), .empty(q_empty));

   tcfa_back u_back (
      .clock(clock), .reset(reset), .in_valid(!q_empty), .in_cmd(q_cmd),
      .in_ready(b_ready), .out_valid(b_valid), .out_rsp(b_rsp),
      .out_ready(!o_full));

   // result queue; pushed responses ride on a distinct packing
   tcfa_rspq u_rspq (
      .clock(clock), .reset(reset), .push(b_valid), .push_data(b_rsp),
      .full(o_full), .pop(rsp_pop), .pop_data(o_rsp), .empty(rsp_empty));

   assign rsp_result_value = o_rsp.value;
   assign rsp_result_kind  = o_rsp.kind;
   assign rsp_error_code   = o_rsp.err;

endmodule
`default_nettype wire

[hdl/tcfa_rspq.sv]
// Two-entry result FIFO feeding the result ports.
`default_nettype none
module tcfa_rspq (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  tcfa_pkg::rsp_type  push_data,
   output logic               full,
   input  wire logic          pop,
   output tcfa_pkg::rsp_type  pop_data,
   output logic               empty
);

   tcfa_pkg::rsp_type mem [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;
   logic       do_push, do_pop;

   assign full     = cnt_ff[1];
   assign empty    = (cnt_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (do_push) wr_ff <= ~wr_ff;
         if (do_pop)  rd_ff <= ~rd_ff;
         if (do_push && !do_pop) cnt_ff <= cnt_ff + 2'd1;
         else if (do_pop && !do_push) cnt_ff <= cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem[wr_ff] <= push_data;
   end

endmodule
`default_nettype wire

[hdl/tcfa_checker.sv]
// Port-level checker for the ALU, bound to the top level.
`default_nettype none
module tcfa_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         rsp_empty,
   input wire logic         rsp_pop,
   input wire logic [63:0]  rsp_result_value,
   input wire logic [1:0]   rsp_result_kind,
   input wire logic [2:0]   rsp_error_code
);

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_error_code != tcfa_pkg::ERR_OK) |->
      (rsp_result_value == '0 && rsp_result_kind == tcfa_pkg::KIND_INT))
      else $error("error result not cleared");

   a_bool_bit: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_result_kind == tcfa_pkg::KIND_BOOL) |->
      (rsp_result_value[63:1] == '0))
      else $error("boolean result wider than one bit");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_result_value)))
      else $error("waiting result changed");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> rsp_empty)
      else $error("result after reset");

endmodule

bind typed_const_fold_alu_top tcfa_checker u_checker (
   .clock(clock), .reset(reset), .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
   .rsp_result_value(rsp_result_value), .rsp_result_kind(rsp_result_kind),
   .rsp_error_code(rsp_error_code));
`default_nettype wire

[tb/sv/typed_const_fold_alu_top_tb.sv]
// Self-checking testbench for the typed constant-folding ALU.
`timescale 1ns / 1ps
module typed_const_fold_alu_top_tb;

   localparam int SetWidth = 32;
   localparam int RandomCount = 1450;
   localparam int CycleLimit = 400000;
   localparam int DirectedCount = 24;

   typedef struct packed {
      logic [4:0]  opcode;
      logic [1:0]  lhs_kind;
      logic [1:0]  rhs_kind;
      logic [63:0] lhs_value;
      logic [63:0] rhs_value;
   } alu_req_type;

   typedef struct packed {
      logic        known;   // expected result typed in the row
      logic [63:0] value;
      logic [1:0]  kind;
      logic [2:0]  err;
   } fold_row_type;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [4:0]  req_opcode;
   logic [1:0]  req_lhs_kind;
   logic [1:0]  req_rhs_kind;
   logic [63:0] req_lhs_value;
   logic [63:0] req_rhs_value;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [63:0] rsp_result_value;
   logic [1:0]  rsp_result_kind;
   logic [2:0]  rsp_error_code;

   tcfa_pkg::rsp_type folded_q[$];
   int          mismatch_count;
   int          cycle_count;
   int          send_idle_pct;
   int          recv_idle_pct;
   int          hold_cycles;

   typed_const_fold_alu_top #(.SET_WIDTH(SetWidth)) dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_opcode(req_opcode), .req_lhs_kind(req_lhs_kind),
      .req_rhs_kind(req_rhs_kind), .req_lhs_value(req_lhs_value),
      .req_rhs_value(req_rhs_value),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_result_value(rsp_result_value), .rsp_result_kind(rsp_result_kind),
      .rsp_error_code(rsp_error_code)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic signed_less(logic [63:0] a, logic [63:0] b);
      return $signed(a) < $signed(b);
   endfunction

   function automatic tcfa_pkg::rsp_type fold_expected(alu_req_type t);
      tcfa_pkg::rsp_type res;
      logic [63:0] a, b, m, ua, ub, q, r;
      logic        na, nb;
      m = (SetWidth >= 64) ? '1 : ((64'd1 << SetWidth) - 64'd1);
      a = t.lhs_value;
      b = t.rhs_value;
      res.value = '0;
      res.kind = tcfa_pkg::KIND_INT;
      res.err = tcfa_pkg::ERR_OK;
      if (t.opcode > tcfa_pkg::OP_NOT) begin
         res.err = tcfa_pkg::ERR_OPCODE;
      end else if (t.opcode == tcfa_pkg::OP_IN) begin
         if (t.lhs_kind != tcfa_pkg::KIND_INT || t.rhs_kind != tcfa_pkg::KIND_SET ||
             a[63] || a >= 64'(SetWidth)) begin
            res.err = tcfa_pkg::ERR_IN_OPND;
         end else begin
            res.value = {63'd0, b[a[5:0]]};
            res.kind = tcfa_pkg::KIND_BOOL;
         end
      end else if (t.opcode == tcfa_pkg::OP_NEG) begin
         if (t.lhs_kind == tcfa_pkg::KIND_INT) res.value = -a;
         else res.err = tcfa_pkg::ERR_KIND_BAD;
      end else if (t.opcode == tcfa_pkg::OP_NOT) begin
         if (t.lhs_kind == tcfa_pkg::KIND_BOOL) begin
            res.value = {63'd0, ~a[0]};
            res.kind = tcfa_pkg::KIND_BOOL;
         end else res.err = tcfa_pkg::ERR_KIND_BAD;
      end else if (t.lhs_kind != t.rhs_kind) begin
         res.err = tcfa_pkg::ERR_KIND_DIF;
      end else if (t.lhs_kind == tcfa_pkg::KIND_INT) begin
         case (t.opcode)
            tcfa_pkg::OP_ADD: res.value = a + b;
            tcfa_pkg::OP_SUB: res.value = a - b;
            tcfa_pkg::OP_MUL: res.value = a * b;
            tcfa_pkg::OP_SLASH, tcfa_pkg::OP_DIV, tcfa_pkg::OP_MOD: begin
               if (b == 0) begin
                  res.err = tcfa_pkg::ERR_DIV_ZERO;
               end else begin
                  na = a[63];
                  nb = b[63];
                  ua = na ? -a : a;
                  ub = nb ? -b : b;
                  q = ua / ub;
                  r = ua % ub;
                  if (na != nb) q = -q;
                  if (na) r = -r;
                  // floor toward minus infinity
                  if (t.opcode != tcfa_pkg::OP_SLASH && r != 0 && (r[63] ^ b[63])) begin
                     q = q - 1;
                     r = r + b;
                  end
                  res.value = (t.opcode == tcfa_pkg::OP_MOD) ? r : q;
               end
            end
            tcfa_pkg::OP_EQ: begin
               res.value = 64'(a == b);
               res.kind = tcfa_pkg::KIND_BOOL;
            end
            tcfa_pkg::OP_NEQ: begin
               res.value = 64'(a != b);
               res.kind = tcfa_pkg::KIND_BOOL;
            end
            tcfa_pkg::OP_LT: begin
               res.value = 64'(signed_less(a, b));
               res.kind = tcfa_pkg::KIND_BOOL;
            end
            tcfa_pkg::OP_LEQ: begin
               res.value = 64'(!signed_less(b, a));
               res.kind = tcfa_pkg::KIND_BOOL;
            end
            tcfa_pkg::OP_GT: begin
               res.value = 64'(signed_less(b, a));
               res.kind = tcfa_pkg::KIND_BOOL;
            end
            tcfa_pkg::OP_GEQ: begin
               res.value = 64'(!signed_less(a, b));
               res.kind = tcfa_pkg::KIND_BOOL;
            end
            default: res.err = tcfa_pkg::ERR_KIND_BAD;
         endcase
      end else if (t.lhs_kind == tcfa_pkg::KIND_BOOL) begin
         res.kind = tcfa_pkg::KIND_BOOL;
         case (t.opcode)
            tcfa_pkg::OP_AND: res.value = {63'd0, a[0] & b[0]};
            tcfa_pkg::OP_OR:  res.value = {63'd0, a[0] | b[0]};
            tcfa_pkg::OP_EQ:  res.value = {63'd0, ~(a[0] ^ b[0])};
            tcfa_pkg::OP_NEQ: res.value = {63'd0, a[0] ^ b[0]};
            default: res.err = tcfa_pkg::ERR_KIND_BAD;
         endcase
      end else if (t.lhs_kind == tcfa_pkg::KIND_SET) begin
         a = a & m;
         b = b & m;
         res.kind = tcfa_pkg::KIND_SET;
         case (t.opcode)
            tcfa_pkg::OP_ADD:   res.value = a | b;
            tcfa_pkg::OP_SUB:   res.value = a & ~b;
            tcfa_pkg::OP_SLASH: res.value = a ^ b;
            tcfa_pkg::OP_MUL:   res.value = a & b;
            tcfa_pkg::OP_EQ: begin
               res.value = 64'(a == b);
               res.kind = tcfa_pkg::KIND_BOOL;
            end
            tcfa_pkg::OP_NEQ: begin
               res.value = 64'(a != b);
               res.kind = tcfa_pkg::KIND_BOOL;
            end
            default:  res.err = tcfa_pkg::ERR_KIND_BAD;
         endcase
      end else begin
         res.err = tcfa_pkg::ERR_KIND_BAD;
      end
      if (res.err != tcfa_pkg::ERR_OK) begin
         res.value = '0;
         res.kind = tcfa_pkg::KIND_INT;
      end
      return res;
   endfunction

   function automatic logic [63:0] rand64();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0: v = 64'(int'($urandom_range(0, 40)) - 20);
         1: v = 64'h8000_0000_0000_0000;
         2: v = 64'h7fff_ffff_ffff_ffff;
         3: v = {32'd0, $urandom};
         4: v = 64'($urandom_range(0, SetWidth + 2));
         default: ;
      endcase
      return v;
   endfunction

   function automatic alu_req_type random_req();
      alu_req_type t;
      t.opcode = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(17, 31))
                                               : 5'($urandom_range(0, 16));
      t.lhs_kind = 2'($urandom_range(0, 2));
      // mostly matching kinds so the operators are reached
      t.rhs_kind = ($urandom_range(0, 9) < 7) ? t.lhs_kind : 2'($urandom_range(0, 3));
      if ($urandom_range(0, 49) == 0) t.lhs_kind = 2'd3;
      if (t.opcode == tcfa_pkg::OP_IN && $urandom_range(0, 3) != 0) begin
         t.lhs_kind = tcfa_pkg::KIND_INT;
         t.rhs_kind = tcfa_pkg::KIND_SET;
      end
      t.lhs_value = rand64();
      t.rhs_value = rand64();
      if (t.opcode == tcfa_pkg::OP_IN && $urandom_range(0, 3) != 0)
         t.lhs_value = 64'($urandom_range(0, SetWidth - 1));
      return t;
   endfunction

   task automatic send_req(alu_req_type t);
      while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push      <= 1'b1;
      req_opcode    <= t.opcode;
      req_lhs_kind  <= t.lhs_kind;
      req_rhs_kind  <= t.rhs_kind;
      req_lhs_value <= t.lhs_value;
      req_rhs_value <= t.rhs_value;
      @(posedge clock);
      while (req_full) @(posedge clock);
      folded_q.push_back(fold_expected(t));
      @(negedge clock);
   endtask

   // directed rows; typed expectations only where obvious
   fold_row_type   fold_rows[DirectedCount];
   alu_req_type    fold_reqs[DirectedCount];

   task automatic load_rows();
      alu_req_type  t;
      fold_row_type e;
      logic [63:0] mn, mx, ones;
      logic [4:0]  op_add, op_sub, op_slash, op_mul, op_div, op_mod, op_and, op_or;
      logic [4:0]  op_eq, op_neq, op_leq, op_geq, op_in, op_neg, op_not;
      logic [1:0]  k_int, k_bool, k_set;
      mn = 64'h8000_0000_0000_0000;
      mx = 64'h7fff_ffff_ffff_ffff;
      ones = '1;
      op_add = tcfa_pkg::OP_ADD;
      op_sub = tcfa_pkg::OP_SUB;
      op_slash = tcfa_pkg::OP_SLASH;
      op_mul = tcfa_pkg::OP_MUL;
      op_div = tcfa_pkg::OP_DIV;
      op_mod = tcfa_pkg::OP_MOD;
      op_and = tcfa_pkg::OP_AND;
      op_or = tcfa_pkg::OP_OR;
      op_eq = tcfa_pkg::OP_EQ;
      op_neq = tcfa_pkg::OP_NEQ;
      op_leq = tcfa_pkg::OP_LEQ;
      op_geq = tcfa_pkg::OP_GEQ;
      op_in = tcfa_pkg::OP_IN;
      op_neg = tcfa_pkg::OP_NEG;
      op_not = tcfa_pkg::OP_NOT;
      k_int = tcfa_pkg::KIND_INT;
      k_bool = tcfa_pkg::KIND_BOOL;
      k_set = tcfa_pkg::KIND_SET;
      for (int i = 0; i < DirectedCount; i++) fold_rows[i] = '0;
      fold_reqs[0]  = {op_add, k_int, k_int, mx, 64'd1};
      fold_rows[0]  = {1'b1, mn, k_int, tcfa_pkg::ERR_OK};
      fold_reqs[1]  = {op_sub, k_int, k_int, mn, 64'd1};
      fold_rows[1]  = {1'b1, mx, k_int, tcfa_pkg::ERR_OK};
      fold_reqs[2]  = {op_div, k_int, k_int, mn, ones};
      fold_rows[2]  = {1'b1, mn, k_int, tcfa_pkg::ERR_OK};
      fold_reqs[3]  = {op_mod, k_int, k_int, mn, ones};
      fold_rows[3]  = {1'b1, 64'd0, k_int, tcfa_pkg::ERR_OK};
      fold_reqs[4]  = {op_div, k_int, k_int, 64'd5, 64'd0};
      fold_rows[4]  = {1'b1, 64'd0, k_int, tcfa_pkg::ERR_DIV_ZERO};
      fold_reqs[5]  = {op_slash, k_int, k_int, ones, 64'd0};
      fold_rows[5]  = {1'b1, 64'd0, k_int, tcfa_pkg::ERR_DIV_ZERO};
      fold_reqs[6]  = {5'd31, k_int, k_int, ones, ones};
      fold_rows[6]  = {1'b1, 64'd0, k_int, tcfa_pkg::ERR_OPCODE};
      fold_reqs[7]  = {op_add, k_int, k_bool, 64'd1, 64'd1};
      fold_rows[7]  = {1'b1, 64'd0, k_int, tcfa_pkg::ERR_KIND_DIF};
      fold_reqs[8]  = {op_and, k_int, k_int, 64'd1, 64'd1};
      fold_rows[8]  = {1'b1, 64'd0, k_int, tcfa_pkg::ERR_KIND_BAD};
      fold_reqs[9]  = {op_eq, 2'd3, 2'd3, 64'd0, 64'd0};
      fold_rows[9]  = {1'b1, 64'd0, k_int, tcfa_pkg::ERR_KIND_BAD};
      fold_reqs[10] = {op_in, k_int, k_set, 64'(SetWidth), ones};
      fold_rows[10] = {1'b1, 64'd0, k_int, tcfa_pkg::ERR_IN_OPND};
      fold_reqs[11] = {op_in, k_int, k_set, ones, ones};
      fold_rows[11] = {1'b1, 64'd0, k_int, tcfa_pkg::ERR_IN_OPND};
      fold_reqs[12] = {op_in, 2'd3, k_set, 64'd0, ones};
      fold_rows[12] = {1'b1, 64'd0, k_int, tcfa_pkg::ERR_IN_OPND};
      fold_reqs[13] = {op_in, k_int, k_set, 64'(SetWidth - 1), ones};
      fold_rows[13] = {1'b1, 64'd1, k_bool, tcfa_pkg::ERR_OK};
      fold_reqs[14] = {op_not, k_bool, 2'd3, ones, 64'd0};
      fold_rows[14] = {1'b1, 64'd0, k_bool, tcfa_pkg::ERR_OK};
      fold_reqs[15] = {op_neg, k_int, k_set, mn, 64'd0};
      fold_rows[15] = {1'b1, mn, k_int, tcfa_pkg::ERR_OK};
      fold_reqs[16] = {op_mod, k_int, k_int, -64'sd7, 64'd3};
      fold_reqs[17] = {op_slash, k_set, k_set, ones, 64'h0f0f};
      fold_reqs[18] = {op_sub, k_set, k_set, ones, 64'hff};
      fold_reqs[19] = {op_mul, k_int, k_int, mx, mx};
      fold_reqs[20] = {op_or, k_bool, k_bool, 64'd2, 64'd1};
      fold_reqs[21] = {op_leq, k_int, k_int, mn, mx};
      fold_reqs[22] = {op_geq, k_int, k_int, mn, mx};
      fold_reqs[23] = {op_neq, k_set, k_set, 64'hffff_0000_0000_0001, 64'd1};
      for (int i = 0; i < DirectedCount; i++) begin
         t = fold_reqs[i];
         e = fold_rows[i];
         if (e.known && {e.value, e.kind, e.err} != fold_expected(t)) begin
            mismatch_count++;
            $display("row %0d: typed result disagrees with predictor", i);
         end
      end
   endtask

   // receiver: pop with random stalls, plus one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= !(recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      tcfa_pkg::rsp_type e;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (folded_q.size() == 0) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10) $display("unexpected transaction: value %h kind %0d err %0d",
                                              rsp_result_value, rsp_result_kind, rsp_error_code);
         end else begin
            e = folded_q.pop_front();
            if (e.value !== rsp_result_value || e.kind !== rsp_result_kind ||
                e.err !== rsp_error_code) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("expected value %h kind %0d err %0d, got value %h kind %0d err %0d",
                           e.value, e.kind, e.err, rsp_result_value, rsp_result_kind,
                           rsp_error_code);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count >= CycleLimit) begin
         $display("typed_const_fold_alu_top: mismatch");
         $finish;
      end
   end

   initial begin
      int tail;
      reset = 1'b1;
      req_push = 1'b0;
      req_opcode = '0;
      req_lhs_kind = '0;
      req_rhs_kind = '0;
      req_lhs_value = '0;
      req_rhs_value = '0;
      rsp_pop = 1'b0;
      mismatch_count = 0;
      cycle_count = 0;
      hold_cycles = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      load_rows();
      for (int i = 0; i < DirectedCount; i++) send_req(fold_reqs[i]);
      for (int i = 0; i < RandomCount; i++) begin
         if (i < RandomCount / 3) begin
            send_idle_pct = 7;
            recv_idle_pct = 53;
         end else if (i < 2 * RandomCount / 3) begin
            send_idle_pct = 53;
            recv_idle_pct = 7;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         // stall the output long enough to back up the input
         if (i == RandomCount - 300) hold_cycles <= 400;
         send_req(random_req());
      end
      req_push <= 1'b0;
      while (folded_q.size() != 0) @(negedge clock);
      tail = 0;
      while (tail < 100) begin
         @(negedge clock);
         tail++;
      end
      if (mismatch_count == 0 && folded_q.size() == 0) begin
         $display("typed_const_fold_alu_top: match");
      end else begin
         $display("typed_const_fold_alu_top: mismatch");
      end
      $finish;
   end

endmodule
